// ===== src/aes_block_cipher_unit_assert.svh =====
// Assertion macros for the AES block cipher unit checker.
// No dependencies.
`ifndef AES_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define AES_BLOCK_CIPHER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define AES_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define AES_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== src/aes_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the AES block cipher unit.
// No dependencies.
package aes_pkg;
  localparam int MaxRoundsDef = 14;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_SIZE  = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD0 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD3 = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aes_out_t;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_RUN
  } ks_state_t;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] bb;
    acc = 8'h00;
    bb = b;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) acc = acc ^ bb;
      bb = xtime(bb);
    end
    gmul = acc;
  endfunction

  // forward S-box
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  // inverse S-box
  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction
endpackage

// ===== src/aes_round.sv =====
// One AES round stage (encrypt or decrypt) with its pipeline register.
// Depends on aes_pkg.
module aes_round (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  logic         dec_i,
  input  logic         act_i,    // round applies; otherwise pass through
  input  logic         last_i,   // final round: mix skipped
  input  logic [127:0] st_i,
  input  logic [127:0] rk_i,
  output logic         vld_o,
  output logic         dec_o,
  output logic [127:0] st_o
);
  logic [7:0]   sb [16];
  logic [7:0]   sr [16];
  logic [7:0]   mx [16];
  logic [7:0]   ak [16];
  logic [127:0] enc_v;
  logic [127:0] dec_v;
  logic [127:0] st_nxt;
  logic         vld_r;
  logic         dec_r;
  logic [127:0] st_r;

  // byte i sits at bits 127-8i; state index is row + 4*col
  always_comb begin
    // encrypt: sub, shift, mix, add
    for (int i = 0; i < 16; i++) sb[i] = aes_pkg::sbox(st_i[127-8*i -: 8]);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) sr[r+4*c] = sb[r+4*((c+r)%4)];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        mx[4*c+i] = aes_pkg::gmul(8'h02, sr[4*c+i]) ^ aes_pkg::gmul(8'h03, sr[4*c+(i+1)%4])
                  ^ sr[4*c+(i+2)%4] ^ sr[4*c+(i+3)%4];
    for (int i = 0; i < 16; i++)
      enc_v[127-8*i -: 8] = (last_i ? sr[i] : mx[i]) ^ rk_i[127-8*i -: 8];
    // decrypt: inverse shift, inverse sub, add, inverse mix
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        sb[r+4*((c+r)%4)] = aes_pkg::inv_sbox(st_i[127-8*(r+4*c) -: 8]);
    for (int i = 0; i < 16; i++) ak[i] = sb[i] ^ rk_i[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        dec_v[127-8*(4*c+i) -: 8] = last_i ? ak[4*c+i] :
          aes_pkg::gmul(8'h0e, ak[4*c+i]) ^ aes_pkg::gmul(8'h0b, ak[4*c+(i+1)%4])
          ^ aes_pkg::gmul(8'h0d, ak[4*c+(i+2)%4]) ^ aes_pkg::gmul(8'h09, ak[4*c+(i+3)%4]);
    st_nxt = !act_i ? st_i : (dec_i ? dec_v : enc_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    dec_r <= dec_i;
    st_r  <= st_nxt;
  end

  assign vld_o = vld_r;
  assign dec_o = dec_r;
  assign st_o  = st_r;
endmodule

// ===== src/aes_block_cipher_unit.sv =====
// Top level of the AES block cipher unit: key registers, key expansion
// sequencer, round-key store and a fully unrolled round pipeline. Uses aes_pkg, aes_round.
//
//  channel | ports                        | handshake
//  in      | start, busy, in_req          | accepted when start && !busy
//  out     | out_strobe, out_res          | one-cycle strobe, no back pressure
//  cfg     | cfg_valid, cfg_ready, ...    | write when cfg_valid && cfg_ready
//
// One block per cycle while busy is low; an accepted request passes the input register,
// then one stage per round (stages past the key's round count pass the state through),
// and the last stage's register drives the result ports. After reset and after any key
// or size write, busy stays high through a load step and then one 32-bit schedule word
// per cycle until the last of the 4*(Nr+1) schedule words is written.
// Results cannot be stalled, so the pipeline never holds.
module aes_block_cipher_unit #(
  parameter int MAX_ROUNDS = aes_pkg::MaxRoundsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  aes_pkg::aes_in_t in_req,
  output logic             out_strobe,
  output aes_pkg::aes_out_t out_res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data
);
  localparam int NW  = 4 * (MAX_ROUNDS + 1);
  localparam int WCW = $clog2(NW + 1);

  logic [1:0]  key_size_r;
  logic [63:0] key_r [4];
  logic        stale_r;
  aes_pkg::ks_state_t ks_r, ks_nxt;
  logic [WCW-1:0] wi_r;
  logic [31:0] win_r [8];   // sliding window of the last Nk words
  logic [7:0]  rc_r;
  logic [3:0]  nk, nkm;
  logic [3:0]  nr_v;
  logic [WCW-1:0] total;
  logic [2:0]  phase_r;     // wi mod nk
  logic [31:0] t, wnew;
  logic [127:0] rk_r [MAX_ROUNDS+1];   // one round key per entry; stages select their own

  assign cfg_ready = 1'b1;
  assign busy = stale_r || (ks_r != aes_pkg::KS_IDLE);

  // key size decode; code 3 behaves as 256-bit
  always_comb begin
    unique case (key_size_r)
      2'd0: begin nk = 4'd4; nr_v = 4'd10; end
      2'd1: begin nk = 4'd6; nr_v = 4'd12; end
      default: begin nk = 4'd8; nr_v = 4'd14; end
    endcase
    if (32'(nr_v) > MAX_ROUNDS) nr_v = 4'(MAX_ROUNDS);
    total = WCW'(4 * (32'(nr_v) + 1));
    nkm = nk - 4'd1;
  end

  // next expanded word from the window
  always_comb begin
    t = win_r[nkm[2:0]];
    if (phase_r == 3'd0)
      t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_r, 24'h0};
    else if (nk == 4'd8 && phase_r == 3'd4)
      t = aes_pkg::sub_word(t);
    wnew = win_r[0] ^ t;
  end

  always_comb begin
    ks_nxt = ks_r;
    unique case (ks_r)
      aes_pkg::KS_IDLE: if (stale_r) ks_nxt = aes_pkg::KS_RUN;
      aes_pkg::KS_RUN:  if (wi_r + WCW'(1) >= total) ks_nxt = aes_pkg::KS_IDLE;
      default:          ks_nxt = aes_pkg::KS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r <= 2'd0;
      for (int i = 0; i < 4; i++) key_r[i] <= 64'h0;
      stale_r <= 1'b1;
      ks_r <= aes_pkg::KS_IDLE;
      wi_r <= '0;
    end else begin
      ks_r <= ks_nxt;
      // register write
      if (cfg_valid && cfg_index <= aes_pkg::CFG_KEY_WORD3) begin
        if (cfg_index == aes_pkg::CFG_KEY_SIZE) key_size_r <= cfg_data[1:0];
        else key_r[cfg_index[1:0] - 2'd1] <= cfg_data;
        stale_r <= 1'b1;
      end else if (ks_r == aes_pkg::KS_IDLE && stale_r) begin
        stale_r <= 1'b0;
      end
      if (ks_r == aes_pkg::KS_IDLE) wi_r <= WCW'(nk);
      else wi_r <= wi_r + WCW'(1);
    end
    // load key words, then slide
    if (ks_r == aes_pkg::KS_IDLE) begin
      for (int i = 0; i < 8; i++) win_r[i] <= key_r[i/2][(i%2==0) ? 63 : 31 -: 32];
      for (int i = 0; i < 8; i++)
        if (4'(i) < nk) rk_r[i/4][127-32*(i%4) -: 32] <= key_r[i/2][(i%2==0) ? 63 : 31 -: 32];
      rc_r <= 8'h01;
      phase_r <= 3'd0;
    end else begin
      for (int i = 0; i < 7; i++) win_r[i] <= (4'(i) == nkm) ? wnew : win_r[i+1];
      win_r[7] <= wnew;
      for (int i = 0; i < NW; i++)
        if (WCW'(i) == wi_r) rk_r[i/4][127-32*(i%4) -: 32] <= wnew;
      if (phase_r == 3'd0) rc_r <= aes_pkg::xtime(rc_r);
      phase_r <= (4'(phase_r) == nkm) ? 3'd0 : phase_r + 3'd1;
    end
  end

  // input stage: initial key add
  logic         v0_r, d0_r;
  logic [127:0] s0_r;
  logic [127:0] rk_first, rk_last;
  always_comb begin
    rk_first = rk_r[0];
    rk_last  = rk_first;
    for (int r = 0; r <= MAX_ROUNDS; r++)
      if (4'(r) == nr_v) rk_last = rk_r[r];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start && !busy;
    d0_r <= in_req.mode;
    s0_r <= {in_req.block_hi, in_req.block_lo} ^ (in_req.mode ? rk_last : rk_first);
  end

  // round pipeline; stage k does encrypt round k+1 or decrypt round nr-1-k
  logic         v [MAX_ROUNDS+1];
  logic         d [MAX_ROUNDS+1];
  logic [127:0] s [MAX_ROUNDS+1];
  assign v[0] = v0_r;
  assign d[0] = d0_r;
  assign s[0] = s0_r;
  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_rnd
    logic         act;
    logic [127:0] rk;
    always_comb begin
      act = 4'(k) < nr_v;
      rk = '0;
      for (int r = 0; r <= MAX_ROUNDS; r++)
        if ((!d[k] && r == k + 1) || (d[k] && 4'(r) + 4'(k) + 4'd1 == nr_v))
          rk = rk_r[r];
    end
    aes_round u_rnd (
      .clk(clk), .rst_n(rst_n), .vld_i(v[k]), .dec_i(d[k]), .act_i(act),
      .last_i(4'(k) + 4'd1 == nr_v), .st_i(s[k]), .rk_i(rk),
      .vld_o(v[k+1]), .dec_o(d[k+1]), .st_o(s[k+1]));
  end

  assign out_strobe = v[MAX_ROUNDS];
  assign out_res.result_hi = s[MAX_ROUNDS][127:64];
  assign out_res.result_lo = s[MAX_ROUNDS][63:0];
endmodule

// ===== src/aes_block_cipher_unit_chk.sv =====
// Port-level checker for the AES block cipher unit, bound to the top level.
// Depends on aes_block_cipher_unit_assert.svh and aes_pkg.
`include "aes_block_cipher_unit_assert.svh"
module aes_block_cipher_unit_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_strobe,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [2:0] cfg_index
);
  // a key or size write forces a schedule run before the next request
  `AES_ASSERT_NXT(a_cfg_busy, clk, rst_n, cfg_valid && cfg_ready && cfg_index <= aes_pkg::CFG_KEY_WORD3, busy)
  // config port never refuses
  `AES_ASSERT_IMP(a_cfg_rdy, clk, rst_n, 1'b1, cfg_ready)
  // handshake outputs are always driven to known levels out of reset
  `AES_ASSERT_IMP(a_known, clk, rst_n, 1'b1, !$isunknown(busy) && !$isunknown(out_strobe))
endmodule

bind aes_block_cipher_unit aes_block_cipher_unit_chk u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_strobe(out_strobe),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index));

// ===== tb/sv/tb.sv =====
// Self-checking testbench for aes_block_cipher_unit: encrypt/decrypt requests
// are predicted by an in-house AES model and compared by a small scoreboard.
// Depends on aes_pkg and the aes_block_cipher_unit RTL.
module tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 1700;
  localparam logic [2:0] REG_SIZE = aes_pkg::CFG_KEY_SIZE;
  localparam logic [2:0] REG_KEY0 = aes_pkg::CFG_KEY_WORD0;
  localparam logic [2:0] REG_LAST = aes_pkg::CFG_KEY_WORD3;
  localparam logic [2:0] REG_BAD = 3'd5;
  localparam logic [2:0] REG_TOP = 3'd7;
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // ---------------------------------------------------------------------
  // AES predictor
  // ---------------------------------------------------------------------
  logic [7:0] fsb [256];
  logic [7:0] isb [256];
  logic [1:0] key_size_q;
  logic [63:0] key_q [4];
  logic [31:0] rk_words [60];
  logic        rk_stale;

  function automatic logic [7:0] x2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) acc ^= b;
      b = x2(b);
    end
    return acc;
  endfunction

  // S-boxes from field inverse plus affine map
  task automatic build_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 0;
      for (int y = 1; y < 256 && x != 0; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) begin
          inv = y[7:0];
          break;
        end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fsb[x] = s;
      isb[s] = x[7:0];
    end
  endtask

  function automatic int nk_of();
    return key_size_q == 0 ? 4 : (key_size_q == 1 ? 6 : 8);
  endfunction

  function automatic int nr_of();
    return key_size_q == 0 ? 10 : (key_size_q == 1 ? 12 : 14);
  endfunction

  function automatic logic [31:0] sw(input logic [31:0] w);
    return {fsb[w[31:24]], fsb[w[23:16]], fsb[w[15:8]], fsb[w[7:0]]};
  endfunction

  task automatic expand_schedule();
    int nk, total;
    logic [7:0] rc;
    logic [31:0] t;
    nk = nk_of();
    total = 4 * (nr_of() + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      rk_words[i] = i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = rk_words[i - 1];
      if (i % nk == 0) begin
        t = sw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = x2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sw(t);
      end
      rk_words[i] = rk_words[i - nk] ^ t;
    end
    rk_stale = 0;
  endtask

  function automatic void cfg_model(input logic [2:0] idx, input logic [63:0] v);
    if (idx == REG_SIZE) key_size_q = (v[1:0] == 2'd3) ? 2'd2 : v[1:0];
    else if (idx <= REG_LAST) key_q[idx[1:0] - 2'd1] = v;
    else return;
    rk_stale = 1;
  endfunction

  // state byte i is column i/4, row i%4
  function automatic logic [127:0] add_rk(input logic [127:0] s, input int r);
    return s ^ {rk_words[4*r], rk_words[4*r+1], rk_words[4*r+2], rk_words[4*r+3]};
  endfunction

  function automatic logic [127:0] sub_all(input logic [127:0] s, input bit inv);
    for (int i = 0; i < 16; i++)
      s[127-8*i -: 8] = inv ? isb[s[127-8*i -: 8]] : fsb[s[127-8*i -: 8]];
    return s;
  endfunction

  function automatic logic [127:0] shift_all(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        if (inv) t[127-8*(r+4*((c+r)&3)) -: 8] = s[127-8*(r+4*c) -: 8];
        else t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)&3)) -: 8];
    return t;
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] s, input bit inv);
    logic [7:0] m [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) col[j] = s[127-8*(4*c+j) -: 8];
      for (int i = 0; i < 4; i++) begin
        acc = 0;
        for (int j = 0; j < 4; j++) acc ^= gf_mul(m[(j - i) & 3], col[j]);
        s[127-8*(4*c+i) -: 8] = acc;
      end
    end
    return s;
  endfunction

  task automatic aes_predict(input aes_pkg::aes_in_t rq, output aes_pkg::aes_out_t res);
    logic [127:0] s;
    int nr;
    if (rk_stale) expand_schedule();
    nr = nr_of();
    s = {rq.block_hi, rq.block_lo};
    if (rq.mode == MODE_ENC) begin
      s = add_rk(s, 0);
      for (int r = 1; r <= nr; r++) begin
        s = shift_all(sub_all(s, 0), 0);
        if (r != nr) s = mix_all(s, 0);
        s = add_rk(s, r);
      end
    end else begin
      s = add_rk(s, nr);
      for (int r = nr - 1; r >= 0; r--) begin
        s = add_rk(sub_all(shift_all(s, 1), 1), r);
        if (r != 0) s = mix_all(s, 1);
      end
    end
    res = s;
  endtask

  // ---------------------------------------------------------------------
  // scoreboard
  // ---------------------------------------------------------------------
  class cipher_scoreboard;
    aes_pkg::aes_out_t pending_blocks[$];
    int errors = 0;

    function void report_bad(aes_pkg::aes_out_t got, aes_pkg::aes_out_t exp_res,
                             string what);
      errors++;
      if (errors <= 10)
        $display("%s: expected %h_%h got %h_%h", what, exp_res.result_hi,
                 exp_res.result_lo, got.result_hi, got.result_lo);
    endfunction

    function void note_request(aes_pkg::aes_out_t exp_res);
      pending_blocks.push_back(exp_res);
    endfunction

    function void check_result(aes_pkg::aes_out_t got);
      aes_pkg::aes_out_t exp_res;
      if (pending_blocks.size() == 0) begin
        report_bad(got, 'x, "unexpected result");
        return;
      end
      exp_res = pending_blocks.pop_front();
      if (got.result_hi !== exp_res.result_hi || got.result_lo !== exp_res.result_lo)
        report_bad(got, exp_res, "block mismatch");
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // DUT and clocking
  // ---------------------------------------------------------------------
  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  aes_pkg::aes_in_t in_req = '0;
  logic out_strobe;
  aes_pkg::aes_out_t out_res;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  cipher_scoreboard sb;
  int cycles = 0;

  aes_block_cipher_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // result monitor and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) sb.check_result(out_res);
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // one write on the config port, then cfg_valid returns low before the task ends
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_model(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // keep_start = the next request follows at once, so start stays high
  task automatic send_request(input aes_pkg::aes_in_t rq, input bit keep_start);
    aes_pkg::aes_out_t exp_res;
    start <= 1;
    in_req <= rq;
    do @(posedge clk); while (busy);
    aes_predict(rq, exp_res);
    sb.note_request(exp_res);
    if (!keep_start) start <= 0;
  endtask

  task automatic drain();
    while (sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    drain();
    write_reg(REG_SIZE, {62'd0, ks});
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY0 + 3'd1, k1);
    write_reg(REG_KEY0 + 3'd2, k2);
    write_reg(REG_KEY0 + 3'd3, k3);
  endtask

  function automatic aes_pkg::aes_in_t rand_req();
    aes_pkg::aes_in_t rq;
    rq.mode = 1'($urandom_range(1));
    rq.block_hi = {$urandom, $urandom};
    rq.block_lo = {$urandom, $urandom};
    return rq;
  endfunction

  task automatic random_burst(input int n);
    int g;
    for (int i = 0; i < n; i++) begin
      g = gap_len();
      send_request(rand_req(), g == 0 && i < n - 1);
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    sb = new();
    build_sboxes();
    key_size_q = 0;
    key_q = '{default: '0};
    rk_stale = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // zero key after reset, then block extremes in both modes
    send_request('{MODE_ENC, 64'h0, 64'h0}, 1);
    send_request('{MODE_DEC, 64'h0, 64'h0}, 1);
    send_request('{MODE_ENC, '1, '1}, 1);
    send_request('{MODE_DEC, '1, '1}, 0);

    // FIPS-197 appendix vectors for each key size
    load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send_request('{MODE_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff}, 1);
    send_request('{MODE_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}, 0);
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
    send_request('{MODE_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff}, 1);
    send_request('{MODE_DEC, '1, 64'h0}, 0);
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f);
    send_request('{MODE_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff}, 1);
    send_request('{MODE_DEC, 64'h0, '1}, 0);

    // unused size code acts as 256-bit; all-ones key; out-of-range index ignored
    load_key(2'd3, '1, '1, '1, '1);
    write_reg(REG_BAD, r64());
    write_reg(REG_TOP, r64());
    send_request('{MODE_ENC, 64'h8000000000000000, 64'h1}, 1);
    send_request('{MODE_DEC, 64'h1, 64'h8000000000000000}, 0);

    // random phases over every key size, with random keys
    for (int ph = 0; ph < 12; ph++) begin
      load_key(2'(ph % 4), r64(), r64(), r64(), r64());
      random_burst(N_RANDOM / 12);
    end
    // single register change mid-run forces a re-expansion
    drain();
    write_reg(REG_KEY0 + 3'd1, r64());
    random_burst(40);

    drain();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/aes_pkg.sv
src/aes_round.sv
src/aes_block_cipher_unit.sv
src/aes_block_cipher_unit_chk.sv
tb/sv/tb.sv
